// ----- sv/aes_pkg.sv -----
// aes_pkg: shared types, constants and byte-level functions for the aes-128 cipher
// no dependencies; used by every module of the cipher
package aes_pkg;

   localparam int NumRounds = 10;
   localparam int BlockBits = 128;
   localparam int CsrIdxBits = 1;

   localparam logic [CsrIdxBits-1:0] CSR_KEY_LOW = 1'b0;
   localparam logic [CsrIdxBits-1:0] CSR_KEY_HIGH = 1'b1;

   typedef logic [BlockBits-1:0] block_type;

   typedef struct packed {
      logic valid;
      logic decrypt;
   } ctl_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   localparam logic [7:0] RCON [NumRounds] = '{
      8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of the block sits at bits 8i+7:8i, column c holds bytes 4c..4c+3
   function automatic block_type mix_columns(input block_type s);
      block_type o;
      logic [7:0] a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = s[32*c +: 8];
         a1 = s[32*c+8 +: 8];
         a2 = s[32*c+16 +: 8];
         a3 = s[32*c+24 +: 8];
         o[32*c +: 8]    = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         o[32*c+8 +: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         o[32*c+16 +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         o[32*c+24 +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      return o;
   endfunction

   // inverse as a premultiply by (04 x^2 + 05) followed by the forward mix
   function automatic block_type inv_mix_columns(input block_type s);
      block_type p;
      logic [7:0] u, v;
      for (int c = 0; c < 4; c++) begin
         u = xtime(xtime(s[32*c +: 8] ^ s[32*c+16 +: 8]));
         v = xtime(xtime(s[32*c+8 +: 8] ^ s[32*c+24 +: 8]));
         p[32*c +: 8]    = s[32*c +: 8] ^ u;
         p[32*c+8 +: 8]  = s[32*c+8 +: 8] ^ v;
         p[32*c+16 +: 8] = s[32*c+16 +: 8] ^ u;
         p[32*c+24 +: 8] = s[32*c+24 +: 8] ^ v;
      end
      return mix_columns(p);
   endfunction

   function automatic block_type sub_shift(input block_type s);
      block_type t;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            t[8*(r+4*c) +: 8] = SBOX[s[8*(r+4*((c+r)%4)) +: 8]];
         end
      end
      return t;
   endfunction

   function automatic block_type inv_sub_shift(input block_type s);
      block_type t;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            t[8*(r+4*((c+r)%4)) +: 8] = INV_SBOX[s[8*(r+4*c) +: 8]];
         end
      end
      return t;
   endfunction

endpackage

// ----- sv/aes_key_sched.sv -----
// aes_key_sched: holds the key and expands the eleven encrypt and decrypt round keys
// depends on aes_pkg; after reset and after each key write the round keys are derived one by one, in round order
module aes_key_sched (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [aes_pkg::CsrIdxBits-1:0]   csr_index,
   input  logic [63:0]                      csr_data,
   output logic                             expanding,
   output aes_pkg::block_type               enc_rk [aes_pkg::NumRounds+1],
   output aes_pkg::block_type               dec_rk [aes_pkg::NumRounds+1]
);

   logic [3:0] step_ff, step_in;
   aes_pkg::block_type key_ff, key_in;
   aes_pkg::block_type rk_ff [aes_pkg::NumRounds+1];
   aes_pkg::block_type next_rk;
   logic [7:0] t0, t1, t2, t3;
   aes_pkg::block_type prev;

   always_comb begin
      key_in = key_ff;
      if (csr_write) begin
         if (csr_index == aes_pkg::CSR_KEY_LOW) key_in[63:0] = csr_data;
         else key_in[127:64] = csr_data;
      end
   end

   // step counts the round key being derived; a key write restarts at round 1
   always_comb begin
      step_in = step_ff;
      if (csr_write) step_in = 4'd1;
      else if (step_ff != 4'd0 && step_ff != 4'(aes_pkg::NumRounds)) step_in = step_ff + 4'd1;
      else if (step_ff == 4'(aes_pkg::NumRounds)) step_in = 4'd0;
   end

   always_comb begin
      prev = rk_ff[step_ff == 4'd0 ? 4'd0 : step_ff - 4'd1];
      t0 = aes_pkg::SBOX[prev[13*8 +: 8]] ^
           aes_pkg::RCON[step_ff == 4'd0 ? 4'd0 : step_ff - 4'd1];
      t1 = aes_pkg::SBOX[prev[14*8 +: 8]];
      t2 = aes_pkg::SBOX[prev[15*8 +: 8]];
      t3 = aes_pkg::SBOX[prev[12*8 +: 8]];
      next_rk[31:0]   = prev[31:0] ^ {t3, t2, t1, t0};
      next_rk[63:32]  = prev[63:32] ^ next_rk[31:0];
      next_rk[95:64]  = prev[95:64] ^ next_rk[63:32];
      next_rk[127:96] = prev[127:96] ^ next_rk[95:64];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 4'd1;
         key_ff  <= '0;
         rk_ff[0] <= '0;
      end else begin
         step_ff <= step_in;
         key_ff  <= key_in;
         if (csr_write) rk_ff[0] <= key_in;
      end
      if (!reset && !csr_write && step_ff != 4'd0) rk_ff[step_ff] <= next_rk;
   end

   assign expanding = (step_ff != 4'd0);

   always_comb begin
      for (int r = 0; r <= aes_pkg::NumRounds; r++) begin
         enc_rk[r] = rk_ff[r];
      end
      dec_rk[0] = rk_ff[aes_pkg::NumRounds];
      for (int r = 1; r < aes_pkg::NumRounds; r++) begin
         dec_rk[r] = aes_pkg::inv_mix_columns(rk_ff[aes_pkg::NumRounds-r]);
      end
      dec_rk[aes_pkg::NumRounds] = rk_ff[0];
   end

endmodule

// ----- sv/aes_round.sv -----
// aes_round: one registered cipher round, forward or inverse per request
// depends on aes_pkg; instantiated once per round by the top level
module aes_round (
   input  logic               clock,
   input  logic               reset,
   input  logic               last,
   input  aes_pkg::ctl_type   ctl_in,
   input  aes_pkg::block_type state_in,
   input  aes_pkg::block_type enc_key,
   input  aes_pkg::block_type dec_key,
   output aes_pkg::ctl_type   ctl_out,
   output aes_pkg::block_type state_out
);

   aes_pkg::ctl_type   ctl_ff;
   aes_pkg::block_type state_ff, state_in_w, sub_w;

   always_comb begin
      if (ctl_in.decrypt) begin
         sub_w = aes_pkg::inv_sub_shift(state_in);
         state_in_w = (last ? sub_w : aes_pkg::inv_mix_columns(sub_w)) ^ dec_key;
      end else begin
         sub_w = aes_pkg::sub_shift(state_in);
         state_in_w = (last ? sub_w : aes_pkg::mix_columns(sub_w)) ^ enc_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      state_ff <= state_in_w;
   end

   assign ctl_out = ctl_ff;
   assign state_out = state_ff;

endmodule

// ----- sv/aes128_block_cipher.sv -----
// aes128_block_cipher: pipelined aes-128 ecb cipher, encrypt and decrypt
// depends on aes_pkg, aes_key_sched and aes_round
// pipeline from start to rsp_valid: input whitening stage, then ten rounds
// throughput: one request per cycle while the round keys are ready; results cannot be stalled
// round keys re-expand after a key write or reset; busy is high meanwhile
// reset is synchronous, active high, clears pipeline valid bits and the key to zero
module aes128_block_cipher (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_kind,
   input  logic [63:0]                    req_block_low,
   input  logic [63:0]                    req_block_high,
   output logic                           rsp_valid,
   output logic [63:0]                    rsp_result_low,
   output logic [63:0]                    rsp_result_high,
   input  logic                           csr_write,
   input  logic [aes_pkg::CsrIdxBits-1:0] csr_index,
   input  logic [63:0]                    csr_data
);

   aes_pkg::block_type enc_rk [aes_pkg::NumRounds+1];
   aes_pkg::block_type dec_rk [aes_pkg::NumRounds+1];
   aes_pkg::ctl_type   ctl [aes_pkg::NumRounds+1];
   aes_pkg::block_type st  [aes_pkg::NumRounds+1];
   aes_pkg::ctl_type   ctl0_ff;
   aes_pkg::block_type st0_ff;

   aes_key_sched u_keys (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .expanding (busy),
      .enc_rk, .dec_rk
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff <= '0;
      end else begin
         ctl0_ff <= '{valid: start & ~busy, decrypt: req_kind};
      end
      st0_ff <= {req_block_high, req_block_low} ^ (req_kind ? dec_rk[0] : enc_rk[0]);
   end

   assign ctl[0] = ctl0_ff;
   assign st[0] = st0_ff;

   for (genvar r = 1; r <= aes_pkg::NumRounds; r++) begin : g_round
      aes_round u_round (
         .clock, .reset,
         .last      (r == aes_pkg::NumRounds),
         .ctl_in    (ctl[r-1]),
         .state_in  (st[r-1]),
         .enc_key   (enc_rk[r]),
         .dec_key   (dec_rk[r]),
         .ctl_out   (ctl[r]),
         .state_out (st[r])
      );
   end

   assign rsp_valid = ctl[aes_pkg::NumRounds].valid;
   assign rsp_result_low = st[aes_pkg::NumRounds][63:0];
   assign rsp_result_high = st[aes_pkg::NumRounds][127:64];

   // every request leaves after a fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      ctl[1].valid |-> ##(aes_pkg::NumRounds-1) rsp_valid)
      else $error("request lost in round pipeline");
   a_kind_travels: assert property (@(posedge clock) disable iff (reset)
      ctl[0].valid |=> ctl[1].decrypt == $past(ctl[0].decrypt))
      else $error("operation bit not carried with request");
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      busy |=> !ctl[0].valid)
      else $error("request taken while busy");

endmodule

// ----- tb/aes128_block_cipher_tb.sv -----
// aes128_block_cipher_tb: self-checking testbench for the pipelined aes-128 ecb cipher
// depends on aes_pkg (csr indexes) and aes128_block_cipher; own aes model predicts results
`timescale 1ns / 100ps
module aes128_block_cipher_tb;

   typedef enum logic {OP_ENCRYPT = 1'b0, OP_DECRYPT = 1'b1} op_kind_type;

   typedef struct {
      op_kind_type kind;
      logic [63:0] lo;
      logic [63:0] hi;
   } cipher_request_type;

   typedef struct {
      logic [63:0] lo;
      logic [63:0] hi;
   } cipher_block_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_kind = 1'b0;
   logic [63:0] req_block_low = '0;
   logic [63:0] req_block_high = '0;
   logic rsp_valid;
   logic [63:0] rsp_result_low;
   logic [63:0] rsp_result_high;
   logic csr_write = 1'b0;
   logic [aes_pkg::CsrIdxBits-1:0] csr_index = aes_pkg::CSR_KEY_LOW;
   logic [63:0] csr_data = '0;

   cipher_request_type pending_requests[$];
   cipher_block_type expected_blocks[$];
   int idle_percent = 0;
   bit failed = 0;
   bit req_taken = 0;

   // predictor state
   logic [7:0] fwd_box[256];
   logic [7:0] rev_box[256];
   logic [7:0] round_key[11][16];
   logic [63:0] key_lo_shadow = '0;
   logic [63:0] key_hi_shadow = '0;

   aes128_block_cipher dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [7:0] gf_double(logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] p;
      p = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = gf_double(a);
      end
      return p;
   endfunction

   // sbox built from the field inverse plus the affine map
   task automatic build_boxes();
      logic [7:0] inv, s;
      for (int x = 0; x < 256; x++) begin
         inv = '0;
         for (int y = 1; y < 256; y++)
            if (gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
         s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
             ^ {inv[3:0], inv[7:4]} ^ 8'h63;
         fwd_box[x] = s;
         rev_box[s] = 8'(x);
      end
   endtask

   task automatic expand_round_keys();
      logic [7:0] w[16];
      logic [7:0] t[4];
      logic [7:0] rc;
      rc = 8'h01;
      for (int i = 0; i < 8; i++) begin
         w[i] = key_lo_shadow[8*i +: 8];
         w[i+8] = key_hi_shadow[8*i +: 8];
      end
      round_key[0] = w;
      for (int r = 1; r <= 10; r++) begin
         t[0] = fwd_box[w[13]] ^ rc;
         t[1] = fwd_box[w[14]];
         t[2] = fwd_box[w[15]];
         t[3] = fwd_box[w[12]];
         for (int c = 0; c < 4; c++)
            for (int k = 0; k < 4; k++) begin
               w[4*c+k] ^= t[k];
               t[k] = w[4*c+k];
            end
         round_key[r] = w;
         rc = gf_double(rc);
      end
   endtask

   function automatic void mix(ref logic [7:0] s[16], input bit inverse);
      logic [7:0] a[4];
      logic [7:0] m[4];
      if (inverse) begin
         m[0] = 8'h0e; m[1] = 8'h0b; m[2] = 8'h0d; m[3] = 8'h09;
      end else begin
         m[0] = 8'h02; m[1] = 8'h03; m[2] = 8'h01; m[3] = 8'h01;
      end
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) a[k] = s[4*c+k];
         for (int k = 0; k < 4; k++)
            s[4*c+k] = gf_mul(a[k], m[0]) ^ gf_mul(a[(k+1)%4], m[1])
                       ^ gf_mul(a[(k+2)%4], m[2]) ^ gf_mul(a[(k+3)%4], m[3]);
      end
   endfunction

   // plain forward and inverse cipher; the inverse gives the same result as the equivalent form used in hardware
   function automatic cipher_block_type aes_transform(cipher_request_type rq);
      logic [7:0] s[16];
      logic [7:0] t[16];
      cipher_block_type res;
      for (int i = 0; i < 8; i++) begin
         s[i] = rq.lo[8*i +: 8];
         s[i+8] = rq.hi[8*i +: 8];
      end
      for (int r = 0; r <= 10; r++) begin
         if (rq.kind == OP_ENCRYPT) begin
            if (r > 0) begin
               for (int row = 0; row < 4; row++)
                  for (int c = 0; c < 4; c++)
                     t[row+4*c] = fwd_box[s[row+4*((c+row)%4)]];
               s = t;
               if (r < 10) mix(s, 0);
            end
            for (int i = 0; i < 16; i++) s[i] ^= round_key[r][i];
         end else begin
            if (r > 0) begin
               for (int row = 0; row < 4; row++)
                  for (int c = 0; c < 4; c++)
                     t[row+4*((c+row)%4)] = rev_box[s[row+4*c]];
               s = t;
            end
            for (int i = 0; i < 16; i++) s[i] ^= round_key[10-r][i];
            if (r > 0 && r < 10) mix(s, 1);
         end
      end
      for (int i = 0; i < 8; i++) begin
         res.lo[8*i +: 8] = s[i];
         res.hi[8*i +: 8] = s[i+8];
      end
      return res;
   endfunction

   // driver: one request per cycle at most, holds a request until it is taken, idles at random
   always @(negedge clock) begin
      if (reset || (start && !req_taken)) begin
      end else if (pending_requests.size() > 0 && $urandom_range(99) >= idle_percent) begin
         cipher_request_type rq;
         rq = pending_requests.pop_front();
         start <= 1'b1;
         req_kind <= rq.kind;
         req_block_low <= rq.lo;
         req_block_high <= rq.hi;
      end else begin
         start <= 1'b0;
      end
   end

   // monitor; also records each accepted request
   always @(posedge clock) begin
      req_taken = !reset && start && !busy;
      if (req_taken) begin
         expected_blocks.push_back(aes_transform('{op_kind_type'(req_kind), req_block_low,
                                                   req_block_high}));
      end
      if (!reset && rsp_valid) begin
         if (expected_blocks.size() == 0) begin
            $display("%0t: unexpected result %h_%h", $realtime, rsp_result_high,
                     rsp_result_low);
            failed = 1;
         end else begin
            cipher_block_type want;
            want = expected_blocks.pop_front();
            if (want.lo !== rsp_result_low) begin
               $display("%0t: result_low expected %h actual %h", $realtime, want.lo,
                        rsp_result_low);
               failed = 1;
            end
            if (want.hi !== rsp_result_high) begin
               $display("%0t: result_high expected %h actual %h", $realtime, want.hi,
                        rsp_result_high);
               failed = 1;
            end
         end
      end
   end

   task automatic drain();
      while (pending_requests.size() > 0 || start || expected_blocks.size() > 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_key(logic [aes_pkg::CsrIdxBits-1:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == aes_pkg::CSR_KEY_LOW) key_lo_shadow = value;
      else key_hi_shadow = value;
      expand_round_keys();
      // the key schedule settles during this wait
      repeat (14) @(negedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic queue_random(int count);
      for (int i = 0; i < count; i++)
         pending_requests.push_back('{op_kind_type'($urandom_range(1)), rand64(), rand64()});
   endtask

   initial begin
      build_boxes();
      expand_round_keys();
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      repeat (14) @(negedge clock);

      // all-zero key straight after reset, field extremes and both kinds
      for (int k = 0; k < 2; k++) begin
         pending_requests.push_back('{op_kind_type'(k), 64'h0, 64'h0});
         pending_requests.push_back('{op_kind_type'(k), '1, '1});
         pending_requests.push_back('{op_kind_type'(k), 64'h5555555555555555,
                                     64'haaaaaaaaaaaaaaaa});
         pending_requests.push_back('{op_kind_type'(k), 64'h8000000000000001,
                                     64'h0123456789abcdef});
      end
      drain();
      // standard test vector key 000102..0f
      write_key(aes_pkg::CSR_KEY_LOW, 64'h0706050403020100);
      write_key(aes_pkg::CSR_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
      pending_requests.push_back('{OP_ENCRYPT, 64'h7766554433221100, 64'hffeeddccbbaa9988});
      pending_requests.push_back('{OP_DECRYPT, 64'hd8e0c469307b6a6a, 64'h5ac5b470808acd7b});
      queue_random(8);
      drain();
      write_key(aes_pkg::CSR_KEY_LOW, '1);
      write_key(aes_pkg::CSR_KEY_HIGH, '1);
      queue_random(8);
      drain();

      for (int phase = 0; phase < 7; phase++) begin
         case (phase % 3)
            0: begin
               idle_percent = 0;
            end
            1: begin
               idle_percent = 58;
            end
            default: begin
               idle_percent = 26;
            end
         endcase
         if (phase == 6) begin
            write_key(aes_pkg::CSR_KEY_LOW, '0);
            write_key(aes_pkg::CSR_KEY_HIGH, '0);
         end else begin
            write_key(aes_pkg::CSR_KEY_LOW, rand64());
            write_key(aes_pkg::CSR_KEY_HIGH, rand64());
         end
         queue_random(195);
         drain();
      end

      drain();
      repeat (20) @(negedge clock);
      if (!failed) begin
         $display("aes128_block_cipher regression: pass");
      end else begin
         $display("aes128_block_cipher regression: fail");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("aes128_block_cipher regression: fail");
      $finish;
   end
endmodule
